@@ src/bes_pkg.sv @@
// Shared types, codes and reset values for the bulb exposure sequencer.
package bes_pkg;

  // Field widths
  localparam int unsigned TimeW  = 24;
  localparam int unsigned ShotW  = 16;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned CfgIdxW = 2;

  // Request kinds on the item channel
  localparam logic [ModeW-1:0] MODE_TICK   = 2'd0;
  localparam logic [ModeW-1:0] MODE_START  = 2'd1;
  localparam logic [ModeW-1:0] MODE_STATUS = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_START_DELAY = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SHUTTER     = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_PAUSE       = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SHOT_COUNT  = 2'd3;

  // Register reset values
  localparam logic [TimeW-1:0] RST_START_DELAY = 24'd1000;
  localparam logic [TimeW-1:0] RST_SHUTTER     = 24'd1000;
  localparam logic [TimeW-1:0] RST_PAUSE       = 24'd1000;
  localparam logic [ShotW-1:0] RST_SHOT_COUNT  = 16'd3;

  // Sequencer phase
  typedef enum logic [PhaseW-1:0] {
    PH_INACTIVE  = 3'd0,
    PH_START_WAIT = 3'd1,
    PH_EXPOSING  = 3'd2,
    PH_AWAIT_CAM = 3'd3,
    PH_PAUSE     = 3'd4
  } phase_t;

  // Live configuration
  typedef struct packed {
    logic [TimeW-1:0] start_delay_ms;
    logic [TimeW-1:0] shutter_ms;
    logic [TimeW-1:0] pause_ms;
    logic [ShotW-1:0] shot_count;
  } cfg_t;

  // One result
  typedef struct packed {
    phase_t           phase;
    logic [ShotW-1:0] shot_number;
    logic             open_shutter;
    logic             close_shutter;
    logic             request_picture;
    logic             sequence_done;
    logic             start_rejected;
  } res_t;

endpackage

@@ src/bes_if.sv @@
// Channel interfaces: items, results and configuration writes.
interface bes_item_if;
  import bes_pkg::*;
  logic             valid;
  logic             ready;
  logic [ModeW-1:0] mode;
  logic             cam_idle;
  modport source (output valid, output mode, output cam_idle, input ready);
  modport sink   (input valid, input mode, input cam_idle, output ready);
endinterface

interface bes_result_if;
  import bes_pkg::*;
  logic              valid;
  logic              ready;
  logic [PhaseW-1:0] phase;
  logic [ShotW-1:0]  shot_number;
  logic              open_shutter;
  logic              close_shutter;
  logic              request_picture;
  logic              sequence_done;
  logic              start_rejected;
  modport source (output valid, output phase, output shot_number, output open_shutter,
                  output close_shutter, output request_picture, output sequence_done,
                  output start_rejected, input ready);
  modport sink   (input valid, input phase, input shot_number, input open_shutter,
                  input close_shutter, input request_picture, input sequence_done,
                  input start_rejected, output ready);
endinterface

interface bes_cfg_if;
  import bes_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [TimeW-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/bes_cfg_regs.sv @@
// Configuration register file for the sequencer.
module bes_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  bes_cfg_if.sink       cfg,
  output bes_pkg::cfg_t cfg_q
);
  import bes_pkg::*;

  // Writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.start_delay_ms <= RST_START_DELAY;
      cfg_q.shutter_ms     <= RST_SHUTTER;
      cfg_q.pause_ms       <= RST_PAUSE;
      cfg_q.shot_count     <= RST_SHOT_COUNT;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_START_DELAY: cfg_q.start_delay_ms <= cfg.data;
        REG_SHUTTER:     cfg_q.shutter_ms     <= cfg.data;
        REG_PAUSE:       cfg_q.pause_ms       <= cfg.data;
        REG_SHOT_COUNT:  cfg_q.shot_count     <= cfg.data[ShotW-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ src/bes_seq.sv @@
// Sequencer state and the single-step next-state and pulse logic.
module bes_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [bes_pkg::ModeW-1:0] mode,
  input  logic                      cam_idle,
  input  bes_pkg::cfg_t             cfg_q,
  output bes_pkg::res_t             res
);
  import bes_pkg::*;

  phase_t           phase_reg, phase_next;
  logic [TimeW-1:0] elapsed_ticks, elapsed_next;
  logic [ShotW-1:0] shot_index, shot_next;
  logic [TimeW-1:0] elapsed_inc;
  logic [TimeW-1:0] limit;
  logic             wait_hit;
  logic             idle_hit;
  logic             last_shot;

  // Timed wait compare for the current phase
  always_comb begin
    case (phase_reg)
      PH_START_WAIT: limit = cfg_q.start_delay_ms;
      PH_EXPOSING:   limit = cfg_q.shutter_ms;
      PH_PAUSE:      limit = cfg_q.pause_ms;
      default:       limit = cfg_q.pause_ms;
    endcase
  end

  assign elapsed_inc = elapsed_ticks + TimeW'(1);
  assign wait_hit    = (elapsed_inc >= limit) || (elapsed_inc == '0);
  assign idle_hit    = (phase_reg == PH_AWAIT_CAM) && cam_idle;
  assign last_shot   = shot_index >= cfg_q.shot_count;

  // Next state
  always_comb begin
    phase_next   = phase_reg;
    elapsed_next = elapsed_ticks;
    shot_next    = shot_index;
    case (mode)
      MODE_START: begin
        if (phase_reg == PH_INACTIVE) begin
          shot_next    = '0;
          elapsed_next = '0;
          if (cfg_q.shot_count != '0) phase_next = PH_START_WAIT;
        end
      end
      MODE_TICK: begin
        case (phase_reg)
          PH_START_WAIT, PH_PAUSE: begin
            elapsed_next = elapsed_inc;
            if (wait_hit) begin
              shot_next    = shot_index + ShotW'(1);
              elapsed_next = '0;
              phase_next   = PH_EXPOSING;
            end
          end
          PH_EXPOSING: begin
            elapsed_next = elapsed_inc;
            if (wait_hit) begin
              elapsed_next = '0;
              phase_next   = PH_AWAIT_CAM;
            end
          end
          default: ;
        endcase
      end
      MODE_STATUS: begin
        if (idle_hit) begin
          elapsed_next = '0;
          phase_next   = last_shot ? PH_INACTIVE : PH_PAUSE;
        end
      end
      default: ;
    endcase
  end

  // Pulses and reported state
  always_comb begin
    res                 = '0;
    res.phase           = phase_next;
    res.shot_number     = shot_next;
    case (mode)
      MODE_START: begin
        res.start_rejected = (phase_reg != PH_INACTIVE);
        res.sequence_done  = (phase_reg == PH_INACTIVE) && (cfg_q.shot_count == '0);
      end
      MODE_TICK: begin
        res.open_shutter  = wait_hit &&
                            ((phase_reg == PH_START_WAIT) || (phase_reg == PH_PAUSE));
        res.close_shutter = wait_hit && (phase_reg == PH_EXPOSING);
      end
      MODE_STATUS: begin
        res.request_picture = idle_hit;
        res.sequence_done   = idle_hit && last_shot;
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= PH_INACTIVE;
      elapsed_ticks <= '0;
      shot_index    <= '0;
    end else if (step) begin
      phase_reg     <= phase_next;
      elapsed_ticks <= elapsed_next;
      shot_index    <= shot_next;
    end
  end

endmodule

@@ src/bulb_exposure_sequencer_core.sv @@
// Top level of the bulb exposure sequencer.
//
//   channel  dir  handshake      payload
//   item     in   valid/ready    mode, cam_idle
//   result   out  valid/ready    phase, shot_number, five pulse flags
//   cfg      in   valid/ready    index, data (ready is always high)
//
// Each request is registered, then stepped through the sequencer into the
// result register: one request per cycle while the result is not stalled.
// The rate is set by the single result register; a stalled result holds the
// input register, and item.ready drops only while both are full.
// Reset (rst, synchronous) loads the register defaults and an inactive phase.
module bulb_exposure_sequencer_core (
  input  logic       clk,
  input  logic       rst,
  bes_item_if.sink   item,
  bes_result_if.source result,
  bes_cfg_if.sink    cfg
);
  import bes_pkg::*;

  logic             s1_valid;
  logic [ModeW-1:0] s1_mode;
  logic             s1_idle;
  logic             advance;
  cfg_t             cfg_q;
  res_t             step_res;
  res_t             res_q;
  logic             res_valid;

  assign advance    = s1_valid && (!res_valid || result.ready);
  assign item.ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      s1_mode <= item.mode;
      s1_idle <= item.cam_idle;
    end
  end

  bes_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cfg_q (cfg_q)
  );

  bes_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .mode     (s1_mode),
    .cam_idle (s1_idle),
    .cfg_q    (cfg_q),
    .res      (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res_q <= step_res;
  end

  assign result.valid           = res_valid;
  assign result.phase           = res_q.phase;
  assign result.shot_number     = res_q.shot_number;
  assign result.open_shutter    = res_q.open_shutter;
  assign result.close_shutter   = res_q.close_shutter;
  assign result.request_picture = res_q.request_picture;
  assign result.sequence_done   = res_q.sequence_done;
  assign result.start_rejected  = res_q.start_rejected;

  // A shot that starts is reported as exposing
  a_open_exposing: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.open_shutter) |-> (result.phase == PH_EXPOSING))
    else $error("open_shutter without exposing phase");

  // A finished sequence is reported as inactive
  a_done_inactive: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.sequence_done) |-> (result.phase == PH_INACTIVE))
    else $error("sequence_done while still active");

  // A rejected start fires no other pulse
  a_reject_alone: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.start_rejected) |->
      !(result.open_shutter || result.close_shutter ||
        result.request_picture || result.sequence_done))
    else $error("start_rejected with another pulse");

  // A pending input request stays registered while the result is stalled
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && res_valid && !result.ready) |=> (s1_valid && $stable(s1_mode)))
    else $error("input register lost a stalled request");

endmodule
